// ===== rtl/pmts_pkg.sv =====
// Shared types and constants of the program map section parser.
package pmts_pkg;

    // Record kinds carried on the output tuser.
    localparam logic [2:0] KIND_HDR_OK   = 3'd0;
    localparam logic [2:0] KIND_LEN_ERR  = 3'd1;
    localparam logic [2:0] KIND_INFO_ERR = 3'd2;
    localparam logic [2:0] KIND_ENTRY    = 3'd3;
    localparam logic [2:0] KIND_END      = 3'd4;

    // Section arithmetic.
    localparam logic [11:0] SEC_LEN_LIMIT = 12'h3FD; // first illegal section length
    localparam logic [11:0] HDR_TAIL_LEN  = 12'd9;   // header bytes after section_length
    localparam logic [12:0] ENTRY_LEN     = 13'd5;   // fixed bytes of one stream entry
    localparam logic [11:0] ENTRY_MIN     = 12'd4;   // budget must exceed this for an entry
    localparam logic [3:0]  CRC_LAST      = 4'd3;    // counter value at the last CRC byte

    // One output record.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  table_id;
        logic [11:0] section_length;
        logic [15:0] program_number;
        logic [4:0]  version_number;
        logic        current_next;
        logic [7:0]  section_number;
        logic [7:0]  last_section_number;
        logic [12:0] pcr_pid;
        logic [11:0] info_length;
        logic [7:0]  stream_type;
        logic [12:0] elementary_pid;
    } t_record;

    // Record handed from the parser to the output stage.
    typedef struct packed {
        logic    valid;
        t_record rec;
    } t_push;

endpackage

// ===== rtl/pmts_parser.sv =====
// Byte-wise section decoder: header, descriptor skipping, stream entries, CRC.
module pmts_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_beat,      // byte accepted this cycle
    input  logic [7:0]     i_byte,
    input  logic           i_start,
    output pmts_pkg::t_push o_push
);
    import pmts_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HEADER, PH_PROG_DESC, PH_ENTRY, PH_ES_DESC, PH_CRC
    } t_phase;

    typedef enum logic [1:0] {
        SUB_TAG, SUB_LEN, SUB_PAYLOAD
    } t_sub;

    t_phase      r_phase, n_phase;
    t_sub        r_sub, n_sub;
    logic [3:0]  r_cnt, n_cnt;

    logic [7:0]  r_table_id, n_table_id;
    logic [11:0] r_sec_len, n_sec_len;
    logic [15:0] r_prog_num, n_prog_num;
    logic [4:0]  r_version, n_version;
    logic        r_cur_next, n_cur_next;
    logic [7:0]  r_sec_num, n_sec_num;
    logic [7:0]  r_last_sec, n_last_sec;
    logic [12:0] r_pcr, n_pcr;
    logic [3:0]  r_pil_hi, n_pil_hi;
    logic [7:0]  r_st, n_st;
    logic [12:0] r_pid, n_pid;
    logic [3:0]  r_esil_hi, n_esil_hi;
    logic [11:0] r_sec_budget, n_sec_budget;
    logic [11:0] r_desc_budget, n_desc_budget;
    logic [7:0]  r_desc_left, n_desc_left;

    logic [11:0] pil, rest, esil, desc_dec;
    logic [12:0] cost;
    logic [7:0]  left_dec;
    logic        desc_done;

    function automatic t_phase next_entry_phase(input logic [11:0] budget);
        return (budget > ENTRY_MIN) ? PH_ENTRY : PH_CRC;
    endfunction

    assign pil      = {r_pil_hi, i_byte};
    assign rest     = r_sec_len - pil;
    assign esil     = {r_esil_hi, i_byte};
    assign cost     = {1'b0, esil} + ENTRY_LEN;
    assign desc_dec = (r_desc_budget != 12'd0) ? r_desc_budget - 12'd1 : 12'd0;
    assign left_dec = (r_desc_left != 8'd0) ? r_desc_left - 8'd1 : 8'd0;

    always_comb begin
        n_phase       = r_phase;
        n_sub         = r_sub;
        n_cnt         = r_cnt;
        n_table_id    = r_table_id;
        n_sec_len     = r_sec_len;
        n_prog_num    = r_prog_num;
        n_version     = r_version;
        n_cur_next    = r_cur_next;
        n_sec_num     = r_sec_num;
        n_last_sec    = r_last_sec;
        n_pcr         = r_pcr;
        n_pil_hi      = r_pil_hi;
        n_st          = r_st;
        n_pid         = r_pid;
        n_esil_hi     = r_esil_hi;
        n_sec_budget  = r_sec_budget;
        n_desc_budget = r_desc_budget;
        n_desc_left   = r_desc_left;
        desc_done     = 1'b0;

        o_push.valid                   = 1'b0;
        o_push.rec.kind                = KIND_END;
        o_push.rec.table_id            = r_table_id;
        o_push.rec.section_length      = r_sec_len;
        o_push.rec.program_number      = r_prog_num;
        o_push.rec.version_number      = r_version;
        o_push.rec.current_next        = r_cur_next;
        o_push.rec.section_number      = r_sec_num;
        o_push.rec.last_section_number = r_last_sec;
        o_push.rec.pcr_pid             = r_pcr;
        o_push.rec.info_length         = 12'd0;
        o_push.rec.stream_type         = 8'd0;
        o_push.rec.elementary_pid      = 13'd0;

        if (i_beat) begin
            if (i_start) begin
                // A start flag always restarts, whatever was in progress.
                n_table_id = i_byte;
                n_cnt      = 4'd1;
                n_phase    = PH_HEADER;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        n_cnt = r_cnt + 4'd1;
                        case (r_cnt)
                            4'd1:  n_sec_len[11:8] = i_byte[3:0];
                            4'd2:  n_sec_len[7:0]  = i_byte;
                            4'd3:  n_prog_num[15:8] = i_byte;
                            4'd4:  n_prog_num[7:0]  = i_byte;
                            4'd5: begin
                                n_version  = i_byte[5:1];
                                n_cur_next = i_byte[0];
                            end
                            4'd6:  n_sec_num  = i_byte;
                            4'd7:  n_last_sec = i_byte;
                            4'd8:  n_pcr[12:8] = i_byte[4:0];
                            4'd9:  n_pcr[7:0]  = i_byte;
                            4'd10: n_pil_hi   = i_byte[3:0];
                            default: begin
                                // Last header byte: check lengths and emit.
                                n_cnt                  = r_cnt;
                                o_push.valid           = 1'b1;
                                o_push.rec.info_length = pil;
                                if (r_sec_len >= SEC_LEN_LIMIT) begin
                                    o_push.rec.kind = KIND_LEN_ERR;
                                    n_phase         = PH_IDLE;
                                end else if (r_sec_len <= pil) begin
                                    o_push.rec.kind = KIND_INFO_ERR;
                                    n_phase         = PH_IDLE;
                                end else begin
                                    o_push.rec.kind = KIND_HDR_OK;
                                    n_sec_budget = (rest > HDR_TAIL_LEN) ?
                                                   rest - HDR_TAIL_LEN : 12'd0;
                                    if (pil != 12'd0) begin
                                        n_desc_budget = pil;
                                        n_sub         = SUB_TAG;
                                        n_desc_left   = 8'd0;
                                        n_phase       = PH_PROG_DESC;
                                    end else begin
                                        n_cnt   = 4'd0;
                                        n_phase = next_entry_phase(n_sec_budget);
                                    end
                                end
                            end
                        endcase
                    end
                    PH_PROG_DESC, PH_ES_DESC: begin
                        n_desc_budget = desc_dec;
                        case (r_sub)
                            SUB_TAG: n_sub = SUB_LEN;
                            SUB_LEN: begin
                                n_desc_left = i_byte;
                                if (i_byte == 8'd0) begin
                                    n_sub     = SUB_TAG;
                                    desc_done = (desc_dec == 12'd0);
                                end else begin
                                    n_sub = SUB_PAYLOAD;
                                end
                            end
                            default: begin
                                n_desc_left = left_dec;
                                if (left_dec == 8'd0) begin
                                    n_sub     = SUB_TAG;
                                    desc_done = (desc_dec == 12'd0);
                                end
                            end
                        endcase
                        if (desc_done) begin
                            n_cnt   = 4'd0;
                            n_phase = next_entry_phase(r_sec_budget);
                        end
                    end
                    PH_ENTRY: begin
                        n_cnt = r_cnt + 4'd1;
                        case (r_cnt)
                            4'd0: n_st        = i_byte;
                            4'd1: n_pid[12:8] = i_byte[4:0];
                            4'd2: n_pid[7:0]  = i_byte;
                            4'd3: n_esil_hi   = i_byte[3:0];
                            default: begin
                                n_cnt                     = r_cnt;
                                o_push.valid              = 1'b1;
                                o_push.rec.kind           = KIND_ENTRY;
                                o_push.rec.info_length    = esil;
                                o_push.rec.stream_type    = r_st;
                                o_push.rec.elementary_pid = r_pid;
                                n_sec_budget = ({1'b0, r_sec_budget} > cost) ?
                                               12'({1'b0, r_sec_budget} - cost) : 12'd0;
                                if (esil != 12'd0) begin
                                    n_desc_budget = esil;
                                    n_sub         = SUB_TAG;
                                    n_desc_left   = 8'd0;
                                    n_phase       = PH_ES_DESC;
                                end else begin
                                    n_cnt   = 4'd0;
                                    n_phase = next_entry_phase(n_sec_budget);
                                end
                            end
                        endcase
                    end
                    PH_CRC: begin
                        if (r_cnt >= CRC_LAST) begin
                            o_push.valid    = 1'b1;
                            o_push.rec.kind = KIND_END;
                            n_phase         = PH_IDLE;
                            n_cnt           = 4'd0;
                        end else begin
                            n_cnt = r_cnt + 4'd1;
                        end
                    end
                    default: ; // idle: stray bytes are dropped
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sub   <= SUB_TAG;
            r_cnt   <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_sub   <= n_sub;
            r_cnt   <= n_cnt;
        end
        r_table_id    <= n_table_id;
        r_sec_len     <= n_sec_len;
        r_prog_num    <= n_prog_num;
        r_version     <= n_version;
        r_cur_next    <= n_cur_next;
        r_sec_num     <= n_sec_num;
        r_last_sec    <= n_last_sec;
        r_pcr         <= n_pcr;
        r_pil_hi      <= n_pil_hi;
        r_st          <= n_st;
        r_pid         <= n_pid;
        r_esil_hi     <= n_esil_hi;
        r_sec_budget  <= n_sec_budget;
        r_desc_budget <= n_desc_budget;
        r_desc_left   <= n_desc_left;
    end

endmodule

// ===== rtl/pmts_out_skid.sv =====
// Output record register with one skid entry.
module pmts_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pmts_pkg::t_push   i_push,
    output logic              o_ready,   // room for a new byte's record
    output logic              o_valid,
    input  logic              i_ready,
    output pmts_pkg::t_record o_rec
);
    import pmts_pkg::*;

    logic    r_out_v, r_skid_v;
    t_record r_out, r_skid;

    assign o_ready = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_rec   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_ready) begin
            r_out_v  <= r_skid_v | i_push.valid;
            r_skid_v <= 1'b0;
        end else if (i_push.valid) begin
            r_skid_v <= 1'b1;
        end
        if (!r_out_v || i_ready) begin
            r_out <= r_skid_v ? r_skid : i_push.rec;
        end else if (i_push.valid) begin
            r_skid <= i_push.rec;
        end
    end

endmodule

// ===== rtl/pmt_section_parser.sv =====
// Top level of the MPEG-2 program map section parser.
//
//  channel  | dir | tdata                          | tuser          | tlast
//  ---------+-----+--------------------------------+----------------+------
//  s_axis   | in  | section byte                   | section_start  | -
//  m_axis   | out | decoded record fields (104 b)  | record_kind    | -
//
// One byte beat is taken every cycle while s_axis_tready is high. A record
// is registered in the output register, or in the skid entry while m_axis
// stalls; the parser state lives in pmts_parser, the result register and
// one skid entry in pmts_out_skid. s_axis_tready falls only while both
// the output register and the skid entry hold records, i.e. after a record
// is stalled on m_axis and another arrives behind it. Reset is synchronous,
// active low, and leaves the parser idle with both output entries empty.
module pmt_section_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]    s_axis_tuser,   // [0] section_start
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [7:0] table_id, [19:8] section_length, [35:20] program_number,
    // [40:36] version_number, [41] current_next, [49:42] section_number,
    // [57:50] last_section_number, [70:58] pcr_pid, [82:71] info_length,
    // [90:83] stream_type, [103:91] elementary_pid
    output logic [103:0]  m_axis_tdata,
    output logic [2:0]    m_axis_tuser    // [2:0] record_kind
);
    import pmts_pkg::*;

    logic    beat;
    t_push   push;
    t_record rec;

    // A byte beat completes only when the skid entry is free.
    assign beat = s_axis_tvalid && s_axis_tready;

    pmts_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (beat),
        .i_byte  (s_axis_tdata),
        .i_start (s_axis_tuser[0]),
        .o_push  (push)
    );

    pmts_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rec   (rec)
    );

    // Pack record fields, first field in the lowest bits.
    assign m_axis_tuser = rec.kind;
    assign m_axis_tdata = {rec.elementary_pid, rec.stream_type, rec.info_length,
                           rec.pcr_pid, rec.last_section_number, rec.section_number,
                           rec.current_next, rec.version_number, rec.program_number,
                           rec.section_length, rec.table_id};

endmodule

// ===== rtl/pmts_checker.sv =====
// Port-level checks of the section parser, bound to the top level.
module pmts_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser
);
    import pmts_pkg::*;

    // A stalled record beat stays up.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("record beat dropped while stalled");

    // A stalled record keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("record payload changed while stalled");

    // Only defined record kinds leave the block.
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == KIND_HDR_OK || m_axis_tuser == KIND_LEN_ERR ||
                           m_axis_tuser == KIND_INFO_ERR || m_axis_tuser == KIND_ENTRY ||
                           m_axis_tuser == KIND_END))
        else $error("undefined record kind");

    // Byte input backs off only when a record is waiting at the output.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // Reset empties the output and frees the input.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output not empty after reset");

endmodule

bind pmt_section_parser pmts_checker u_pmts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/pmts_record_checker.sv =====
// Record checker for the program map section parser: predicts and compares records.
`timescale 1ns / 1ps

module pmts_record_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    input  logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]    s_axis_tuser,   // [0] section_start
    input  logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [7:0] table_id, [19:8] section_length, [35:20] program_number,
    // [40:36] version_number, [41] current_next, [49:42] section_number,
    // [57:50] last_section_number, [70:58] pcr_pid, [82:71] info_length,
    // [90:83] stream_type, [103:91] elementary_pid
    input  logic [103:0]  m_axis_tdata,
    input  logic [2:0]    m_axis_tuser,   // [2:0] record_kind
    output int            o_mismatches,
    output int            o_pending
);

    import pmts_pkg::*;

    typedef enum logic [2:0] {
        P_IDLE, P_HEADER, P_PROG_DESC, P_ENTRY, P_ES_DESC, P_CRC
    } t_parse_phase;

    typedef enum logic [1:0] {D_TAG, D_LEN, D_PAYLOAD} t_desc_step;

    // Shadow of the parser state.
    t_parse_phase phase;
    logic [3:0]   byte_cnt;
    t_record      hdr;          // info_length holds program info length
    logic [7:0]   es_type;
    logic [12:0]  es_pid;
    logic [11:0]  es_info;
    logic [11:0]  sec_budget;
    logic [11:0]  desc_budget;
    logic [8:0]   desc_left;
    t_desc_step   desc_step;

    t_record      expected_records[$];

    function automatic t_record make_record(input logic [2:0] kind, input logic [11:0] info,
                                            input logic [7:0] st, input logic [12:0] pid);
        t_record rec;
        rec = hdr;
        rec.kind = kind;
        rec.info_length = info;
        rec.stream_type = st;
        rec.elementary_pid = pid;
        return rec;
    endfunction

    task automatic start_next_entry();
        byte_cnt = 4'd0;
        phase = (sec_budget > ENTRY_MIN) ? P_ENTRY : P_CRC;
    endtask

    task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
        o_mismatches++;
        if (o_mismatches <= 10)
            $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_record    want;
        t_record    got;
        logic [7:0] b;
        logic       done;
        int         rest;
        int         cost;
        if (!i_rst_n) begin
            phase = P_IDLE;
            byte_cnt = '0;
            hdr = '0;
            es_type = '0;
            es_pid = '0;
            es_info = '0;
            sec_budget = '0;
            desc_budget = '0;
            desc_left = '0;
            desc_step = D_TAG;
            expected_records.delete();
            o_mismatches = 0;
        end else begin
            // Output side first: a record never leaves in the cycle of its own byte.
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind                = m_axis_tuser;
                got.table_id            = m_axis_tdata[7:0];
                got.section_length      = m_axis_tdata[19:8];
                got.program_number      = m_axis_tdata[35:20];
                got.version_number      = m_axis_tdata[40:36];
                got.current_next        = m_axis_tdata[41];
                got.section_number      = m_axis_tdata[49:42];
                got.last_section_number = m_axis_tdata[57:50];
                got.pcr_pid             = m_axis_tdata[70:58];
                got.info_length         = m_axis_tdata[82:71];
                got.stream_type         = m_axis_tdata[90:83];
                got.elementary_pid      = m_axis_tdata[103:91];
                if (expected_records.size() == 0) begin
                    report("record with none expected, kind", '0, got.kind);
                end else begin
                    want = expected_records.pop_front();
                    if (got.kind !== want.kind)
                        report("record_kind", want.kind, got.kind);
                    if (got.table_id !== want.table_id)
                        report("table_id", want.table_id, got.table_id);
                    if (got.section_length !== want.section_length)
                        report("section_length", want.section_length, got.section_length);
                    if (got.program_number !== want.program_number)
                        report("program_number", want.program_number, got.program_number);
                    if (got.version_number !== want.version_number)
                        report("version_number", want.version_number, got.version_number);
                    if (got.current_next !== want.current_next)
                        report("current_next", want.current_next, got.current_next);
                    if (got.section_number !== want.section_number)
                        report("section_number", want.section_number, got.section_number);
                    if (got.last_section_number !== want.last_section_number)
                        report("last_section_number", want.last_section_number,
                               got.last_section_number);
                    if (got.pcr_pid !== want.pcr_pid)
                        report("pcr_pid", want.pcr_pid, got.pcr_pid);
                    if (got.info_length !== want.info_length)
                        report("info_length", want.info_length, got.info_length);
                    if (got.stream_type !== want.stream_type)
                        report("stream_type", want.stream_type, got.stream_type);
                    if (got.elementary_pid !== want.elementary_pid)
                        report("elementary_pid", want.elementary_pid, got.elementary_pid);
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                b = s_axis_tdata;
                if (s_axis_tuser[0]) begin
                    // Start byte restarts the section from any phase.
                    hdr = '0;
                    hdr.table_id = b;
                    es_type = '0;
                    es_pid = '0;
                    es_info = '0;
                    byte_cnt = 4'd1;
                    phase = P_HEADER;
                end else begin
                    case (phase)
                        P_HEADER: begin
                            done = 1'b0;
                            case (byte_cnt)
                                4'd1:  hdr.section_length = {b[3:0], 8'h00};
                                4'd2:  hdr.section_length = hdr.section_length | b;
                                4'd3:  hdr.program_number = {b, 8'h00};
                                4'd4:  hdr.program_number = hdr.program_number | b;
                                4'd5: begin
                                    hdr.version_number = b[5:1];
                                    hdr.current_next = b[0];
                                end
                                4'd6:  hdr.section_number = b;
                                4'd7:  hdr.last_section_number = b;
                                4'd8:  hdr.pcr_pid = {b[4:0], 8'h00};
                                4'd9:  hdr.pcr_pid = hdr.pcr_pid | b;
                                4'd10: hdr.info_length = {b[3:0], 8'h00};
                                default: begin
                                    hdr.info_length = hdr.info_length | b;
                                    done = 1'b1;
                                end
                            endcase
                            if (!done) begin
                                byte_cnt = byte_cnt + 4'd1;
                            end else if (hdr.section_length >= SEC_LEN_LIMIT) begin
                                expected_records.push_back(
                                    make_record(KIND_LEN_ERR, hdr.info_length, '0, '0));
                                phase = P_IDLE;
                            end else if (hdr.section_length <= hdr.info_length) begin
                                expected_records.push_back(
                                    make_record(KIND_INFO_ERR, hdr.info_length, '0, '0));
                                phase = P_IDLE;
                            end else begin
                                expected_records.push_back(
                                    make_record(KIND_HDR_OK, hdr.info_length, '0, '0));
                                rest = int'(hdr.section_length) - int'(hdr.info_length);
                                sec_budget = (rest > int'(HDR_TAIL_LEN))
                                           ? 12'(rest - int'(HDR_TAIL_LEN)) : '0;
                                if (hdr.info_length != '0) begin
                                    desc_budget = hdr.info_length;
                                    desc_step = D_TAG;
                                    desc_left = '0;
                                    phase = P_PROG_DESC;
                                end else begin
                                    start_next_entry();
                                end
                            end
                        end
                        P_PROG_DESC, P_ES_DESC: begin
                            done = 1'b0;
                            if (desc_budget != '0)
                                desc_budget = desc_budget - 12'd1;
                            case (desc_step)
                                D_TAG: desc_step = D_LEN;
                                D_LEN: begin
                                    desc_left = {1'b0, b};
                                    if (b == 8'd0) begin
                                        desc_step = D_TAG;
                                        done = (desc_budget == '0);
                                    end else begin
                                        desc_step = D_PAYLOAD;
                                    end
                                end
                                default: begin
                                    if (desc_left != '0)
                                        desc_left = desc_left - 9'd1;
                                    if (desc_left == '0) begin
                                        desc_step = D_TAG;
                                        done = (desc_budget == '0);
                                    end
                                end
                            endcase
                            if (done)
                                start_next_entry();
                        end
                        P_ENTRY: begin
                            done = 1'b0;
                            case (byte_cnt)
                                4'd0: es_type = b;
                                4'd1: es_pid = {b[4:0], 8'h00};
                                4'd2: es_pid = es_pid | b;
                                4'd3: es_info = {b[3:0], 8'h00};
                                default: begin
                                    done = 1'b1;
                                    es_info = es_info | b;
                                    expected_records.push_back(
                                        make_record(KIND_ENTRY, es_info, es_type, es_pid));
                                    cost = int'(es_info) + int'(ENTRY_LEN);
                                    sec_budget = (int'(sec_budget) > cost)
                                               ? 12'(int'(sec_budget) - cost) : '0;
                                    if (es_info != '0) begin
                                        desc_budget = es_info;
                                        desc_step = D_TAG;
                                        desc_left = '0;
                                        phase = P_ES_DESC;
                                    end else begin
                                        start_next_entry();
                                    end
                                end
                            endcase
                            if (!done)
                                byte_cnt = byte_cnt + 4'd1;
                        end
                        P_CRC: begin
                            // CRC bytes are counted, never checked.
                            if (byte_cnt >= CRC_LAST) begin
                                expected_records.push_back(make_record(KIND_END, '0, '0, '0));
                                phase = P_IDLE;
                                byte_cnt = '0;
                            end else begin
                                byte_cnt = byte_cnt + 4'd1;
                            end
                        end
                        default: ;  // idle bytes are dropped
                    endcase
                end
            end
        end
        o_pending = expected_records.size();
    end

endmodule

// ===== tb/tb_pmt_section_parser.sv =====
// Testbench top for the program map section parser: section stimulus and verdict.
`timescale 1ns / 1ps

module tb_pmt_section_parser;

    // Content modes for generated bytes.
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    // Wait modes, shared by sender and receiver.
    localparam int GAP_NONE   = 0;
    localparam int GAP_RANDOM = 1;
    localparam int GAP_SPARSE = 2;

    // Byte beats for the whole run, directed sections included.
    localparam int TOTAL_BYTES = 1050;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [7:0]    s_axis_tdata;   // [7:0] data_byte
    logic [0:0]    s_axis_tuser;   // [0] section_start
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    // [7:0] table_id, [19:8] section_length, [35:20] program_number,
    // [40:36] version_number, [41] current_next, [49:42] section_number,
    // [57:50] last_section_number, [70:58] pcr_pid, [82:71] info_length,
    // [90:83] stream_type, [103:91] elementary_pid
    logic [103:0]  m_axis_tdata;
    logic [2:0]    m_axis_tuser;   // [2:0] record_kind

    int            mismatches;
    int            records_pending;

    // One section as beats, {section_start, data_byte}.
    logic [8:0]    section_beats[$];
    int            beats_sent = 0;
    int            tx_mode;
    int            rx_mode;
    int            rx_stall;
    logic          rx_fire;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    pmt_section_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pmts_record_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_mismatches  (mismatches),
        .o_pending     (records_pending)
    );

    function automatic int draw_wait(input int mode);
        case (mode)
            GAP_NONE:   return 0;
            GAP_RANDOM: return $urandom_range(0, 16);
            default:    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    function automatic logic [7:0] fill_byte(input int fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Receiver: after each record beat, hold tready low for a drawn number of cycles.
    always @(posedge i_clk)
        rx_fire <= m_axis_tvalid && m_axis_tready;

    always @(negedge i_clk) begin
        if (rx_fire === 1'b1) begin
            if ($urandom_range(0, 39) == 0)
                rx_mode = $urandom_range(0, 2);
            rx_stall = draw_wait(rx_mode);
        end
        if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Descriptor loop bytes (tag, length, payload) aiming at 'target' bytes. A
    // descriptor that fits exactly closes the loop; one byte left over makes
    // the last descriptor run past the budget.
    task automatic add_descriptors(input int target, input int desc_max, input int fill,
                                   output int produced);
        int lim;
        int rem;
        int len;
        lim = (desc_max < 255) ? desc_max : 255;
        produced = 0;
        while (produced < target) begin
            rem = target - produced;
            if (rem >= 2 && rem - 2 <= lim)
                len = rem - 2;
            else
                len = $urandom_range(0, lim);
            section_beats.push_back({1'b0, fill_byte(fill)});
            section_beats.push_back({1'b0, 8'(len)});
            repeat (len) section_beats.push_back({1'b0, fill_byte(fill)});
            produced += 2 + len;
        end
    endtask

    // Random non-start bytes, with a start byte about once in start_odds.
    task automatic add_noise(input int count, input int start_odds);
        repeat (count) begin
            section_beats.push_back({start_odds > 0 && $urandom_range(1, start_odds) == 1,
                                     fill_byte(FILL_RANDOM)});
        end
    endtask

    // Builds one section into section_beats. section_length counts the bytes
    // after itself unless forced; sl_jitter and pil_skew break the framing.
    // cut > 0 keeps only the first cut bytes, so the next start restarts it.
    task automatic build_section(input int n_entries, input int pil, input int pil_skew,
                                 input int desc_max, input int sl_force, input int sl_jitter,
                                 input int fill, input int cut);
        logic [7:0]  fb;
        logic [11:0] sl_field;
        logic [11:0] es_field;
        int          body;
        int          produced;
        int          esil;
        int          sl;
        section_beats.delete();
        section_beats.push_back({1'b1, fill_byte(fill)});      // table_id
        section_beats.push_back(9'h000);                        // length, patched below
        section_beats.push_back(9'h000);
        repeat (7) section_beats.push_back({1'b0, fill_byte(fill)}); // program .. pcr_pid
        fb = fill_byte(fill);
        section_beats.push_back({1'b0, fb[7:4], 4'(pil >> 8)});
        section_beats.push_back({1'b0, 8'(pil)});
        body = 9;
        add_descriptors(pil + pil_skew, desc_max, fill, produced);
        body += produced;
        repeat (n_entries) begin
            case (fill)
                FILL_ZERO: esil = 0;
                FILL_ONES: esil = desc_max;
                default:   esil = $urandom_range(0, desc_max);
            endcase
            es_field = 12'(esil);
            section_beats.push_back({1'b0, fill_byte(fill)});  // stream_type
            section_beats.push_back({1'b0, fill_byte(fill)});  // pid high, reserved bits
            section_beats.push_back({1'b0, fill_byte(fill)});
            fb = fill_byte(fill);
            section_beats.push_back({1'b0, fb[7:4], es_field[11:8]});
            section_beats.push_back({1'b0, es_field[7:0]});
            add_descriptors(esil, desc_max, fill, produced);
            body += 5 + produced;
        end
        repeat (4) section_beats.push_back({1'b0, fill_byte(fill)}); // CRC, never checked
        body += 4;
        sl = (sl_force >= 0) ? sl_force : body + sl_jitter;
        if (sl < 0)
            sl = 0;
        if (sl > 4095)
            sl = 4095;
        sl_field = 12'(sl);
        fb = fill_byte(fill);
        section_beats[1] = {1'b0, fb[7:4], sl_field[11:8]};
        section_beats[2] = {1'b0, sl_field[7:0]};
        if (cut > 0)
            while (section_beats.size() > cut) void'(section_beats.pop_back());
    endtask

    // One byte beat; the gap before it is drawn per beat.
    task automatic send_beat(input logic [8:0] beat);
        int gap;
        gap = draw_wait(tx_mode);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat[7:0];
        s_axis_tuser  <= beat[8];
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_section();
        foreach (section_beats[i]) send_beat(section_beats[i]);
        beats_sent += section_beats.size();
    endtask

    // Sender holds off until every predicted record has been taken.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (records_pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int  pick;
        bit  paused;
        int  pil;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        rx_fire       = 1'b0;
        rx_stall      = 0;
        rx_mode       = GAP_NONE;
        tx_mode       = GAP_NONE;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sections.
        build_section(0, 0, 0, 0, -1, 0, FILL_ZERO, 0);         // all-zero fields, no entry
        send_section();
        build_section(2, 0, 0, 0, -1, 0, FILL_ONES, 0);         // maximal header and pids
        send_section();
        tx_mode = GAP_RANDOM;
        build_section(1, 257, 0, 255, -1, 0, FILL_RANDOM, 0);  // 255-byte descriptor
        send_section();
        build_section(0, 0, 0, 0, 12'hFFF, 0, FILL_ONES, 0);    // length error, all ones
        send_section();
        section_beats.delete();
        add_noise(6, 0);                                         // ignored while idle
        send_section();
        build_section(0, 0, 0, 0, 12'h3FD, 0, FILL_RANDOM, 0);  // first illegal length
        send_section();
        build_section(0, 20, 0, 4, 20, 0, FILL_RANDOM, 0);      // info length equals length
        send_section();
        build_section(0, 0, 0, 0, 0, 0, FILL_ZERO, 0);          // zero length section
        send_section();
        tx_mode = GAP_SPARSE;
        build_section(0, 4095, 0, 8, 12'h3FC, 0, FILL_RANDOM, 14); // maximal info length
        send_section();
        build_section(2, 0, 0, 3, 12'h3FC, 0, FILL_RANDOM, 0);  // last legal length
        send_section();
        build_section(1, 3, 2, 6, -1, 0, FILL_RANDOM, 0);       // descriptor overrun
        send_section();
        build_section(2, 0, 0, 6, -1, -6, FILL_RANDOM, 0);      // budget runs dry
        send_section();
        build_section(1, 0, 0, 4095, -1, 0, FILL_ONES, 30);     // maximal es info, restarted
        send_section();
        tx_mode = GAP_NONE;
        build_section(1, 2, 0, 3, -1, 0, FILL_RANDOM, 6);       // restart inside header
        send_section();
        build_section(3, 6, 0, 5, -1, 0, FILL_RANDOM, 0);
        send_section();
        drain();

        // Random sections fill up the byte count: mostly well formed, some broken,
        // some noise.
        paused = 1'b0;
        while (beats_sent < TOTAL_BYTES) begin
            tx_mode = $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                build_section($urandom_range(0, 4), $urandom_range(0, 12), 0,
                              $urandom_range(0, 8), -1, 0, FILL_RANDOM, 0);
            end else if (pick < 70) begin
                build_section($urandom_range(0, 4), $urandom_range(0, 12),
                              int'($urandom_range(0, 4)) - 2, $urandom_range(0, 8), -1,
                              int'($urandom_range(0, 12)) - 6, FILL_RANDOM, 0);
            end else if (pick < 76) begin
                build_section(0, $urandom_range(0, 4095), 0, 0,
                              $urandom_range(12'h3FD, 12'hFFF), 0, FILL_RANDOM, 12);
            end else if (pick < 80) begin
                pil = $urandom_range(0, 40);
                build_section(0, pil, 0, 4, $urandom_range(0, pil), 0, FILL_RANDOM, 0);
            end else if (pick < 90) begin
                build_section($urandom_range(0, 4), $urandom_range(0, 12), 0,
                              $urandom_range(0, 8), -1, 0, FILL_RANDOM,
                              $urandom_range(1, 40));
            end else if (pick < 95) begin
                section_beats.delete();
                add_noise($urandom_range(5, 20), 8);
            end else begin
                build_section(1, $urandom_range(0, 300), 0, 255, -1, 0, FILL_RANDOM, 0);
            end
            if ($urandom_range(0, 3) == 0)
                add_noise($urandom_range(1, 3), 0);
            send_section();
            if (!paused && beats_sent >= (TOTAL_BYTES * 7) / 8) begin
                drain();
                paused = 1'b1;
            end
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && records_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pmts_pkg.sv
rtl/pmts_parser.sv
rtl/pmts_out_skid.sv
rtl/pmt_section_parser.sv
rtl/pmts_checker.sv
tb/pmts_record_checker.sv
tb/tb_pmt_section_parser.sv
